[src/som_bmu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SOM best-matching-unit package
// Shared widths, command and result codes, the configuration record and the
// exponential decay table of the neighbourhood function.
// ----------------------------------------------------------------------------
package som_bmu_pkg;

    localparam int ROWS      = 16;
    localparam int COLS      = 16;
    localparam int DIMS      = 8;
    localparam int VAL_W     = 24;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 4;
    localparam int DIM_W     = 3;
    localparam int UNIT_W    = ROW_W + COL_W;
    localparam int ADDR_W    = UNIT_W + DIM_W;
    localparam int DIST_W    = 52;
    localparam int EXP_DEPTH = 256;
    localparam int EXP_IDX_W = 8;
    localparam int APB_AW    = 5;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_TRAIN = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_QUERY = 2'd0,
        KIND_TRAIN = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    localparam logic [2:0] REG_HEIGHT = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_DIMS   = 3'd2;
    localparam logic [2:0] REG_RATE   = 3'd3;
    localparam logic [2:0] REG_SCALE  = 3'd4;
    localparam logic [2:0] REG_RADIUS = 3'd5;

    typedef struct packed {
        logic [4:0]  height;
        logic [4:0]  width;
        logic [3:0]  dims;
        logic [15:0] rate;
        logic [15:0] scale;
        logic [4:0]  radius;
    } t_cfg;

    typedef logic [15:0] t_exp_rom [EXP_DEPTH];

    // Entry i holds exp(-16 i / depth) in Q1.15, from a short series raised
    // to the 256th power by repeated squaring.
    function automatic t_exp_rom f_exp_rom();
        t_exp_rom    rom;
        logic [63:0] s;
        logic [63:0] p;
        logic [63:0] e;
        for (int i = 0; i < EXP_DEPTH; i++) begin
            s = (64'(i) << 26) / EXP_DEPTH;
            p = s;
            e = (64'd1 << 30) - s;
            p = (p * s) >> 30;
            e = e + p / 2;
            p = (p * s) >> 30;
            e = e - p / 6;
            p = (p * s) >> 30;
            e = e + p / 24;
            for (int k = 0; k < 8; k++) begin
                e = (e * e + (64'd1 << 29)) >> 30;
            end
            rom[i] = 16'((e + (64'd1 << 14)) >> 15);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = f_exp_rom();

endpackage
`default_nettype wire

[src/som_bmu_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SOM request and result channels
// Valid/ready channels carrying one request or one result each.
// ----------------------------------------------------------------------------
interface som_bmu_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [3:0]         unit_row;
    logic [3:0]         unit_col;
    logic [2:0]         feature_index;
    logic signed [23:0] value;

    modport source(output valid, cmd, unit_row, unit_col, feature_index, value,
                   input ready);
    modport sink(input valid, cmd, unit_row, unit_col, feature_index, value,
                 output ready);
endinterface

interface som_bmu_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [3:0]         best_row;
    logic [3:0]         best_col;
    logic [51:0]        best_distance;
    logic signed [23:0] read_value;

    modport source(output valid, result_kind, best_row, best_col, best_distance,
                   read_value, input ready);
    modport sink(input valid, result_kind, best_row, best_col, best_distance,
                 read_value, output ready);
endinterface
`default_nettype wire

[src/som_bmu_search_and_update_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SOM best-matching-unit search and training update
// Sequencer and datapath around the weight memory.
// ----------------------------------------------------------------------------
// A weight write goes into the memory when it is accepted; a weight read
// passes the registered memory read port. A sample feature that is not the
// last is stored. The last feature starts a search that streams one weight
// per cycle from the memory read port and then copies the weight vector of
// the best unit. A training request then visits each unit of the window in
// turn: it measures the unit's distance, forms the neighbourhood factor in
// S_MUL_HI, S_MUL_LO, S_EXP and S_RATE, and reads, updates and writes its
// weights. New requests are taken only when the previous one has finished;
// a finished result may still wait at the output.
module som_bmu_search_and_update_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    som_bmu_in_if.sink                          i_in,
    som_bmu_out_if.source                       o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [som_bmu_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import som_bmu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RDW, S_ISSUE, S_DRAIN, S_EMIT, S_MUL_HI, S_MUL_LO, S_EXP, S_RATE
    } t_state;

    typedef enum logic [1:0] {
        OP_SEARCH, OP_COPY, OP_TDIST, OP_UPD
    } t_op;

    t_cfg cfg;

    som_bmu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    t_state r_state;
    t_op    r_op;
    logic   r_train;
    logic   r_is_read;
    logic [ROW_W-1:0] r_row, r_rhi;
    logic [COL_W-1:0] r_col, r_clo, r_chi;
    logic [DIM_W-1:0] r_k;
    logic [UNIT_W-1:0] r_best_unit;
    logic [DIST_W-1:0] r_best_sum, r_acc, r_dist;
    logic [41:0] r_ph, r_pl;
    logic [15:0] r_e;
    logic [16:0] r_m;
    logic signed [VAL_W-1:0] r_sample [DIMS];
    logic signed [VAL_W-1:0] r_bvec [DIMS];
    logic signed [VAL_W-1:0] r_rd_val;

    logic r_s1_v, r_s1_first, r_s1_last;
    t_op  r_s1_op;
    logic [DIM_W-1:0] r_s1_k;
    logic [UNIT_W-1:0] r_s1_unit;
    logic r_s2_v, r_s2_first, r_s2_last;
    t_op  r_s2_op;
    logic [DIM_W-1:0] r_s2_k;
    logic [UNIT_W-1:0] r_s2_unit;
    logic [49:0] r_s2_sq;
    logic signed [42:0] r_s2_prod;
    logic signed [VAL_W-1:0] r_s2_w;

    logic r_out_valid;
    t_kind r_out_kind;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;
    logic [DIST_W-1:0] r_out_dist;
    logic signed [VAL_W-1:0] r_out_rd;

    logic [4:0] h;
    logic [4:0] w;
    logic [3:0] d;
    logic [ROW_W-1:0] h_last;
    logic [COL_W-1:0] w_last;
    logic [DIM_W-1:0] d_last;
    logic accept;
    logic last_k;
    logic pipe_empty;
    logic out_free;

    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic signed [VAL_W-1:0] mem_wdata, mem_rdata;

    logic signed [VAL_W-1:0] s1_ref;
    logic signed [24:0] s1_diff, s1_udiff;
    logic signed [49:0] s1_sq;
    logic signed [42:0] s1_prod;

    logic [DIST_W:0] s2_raw;
    logic [DIST_W-1:0] s2_sum;
    logic [42:0] s2_mag, s2_rnd;
    logic signed [28:0] s2_step;
    logic signed [29:0] s2_new;
    logic signed [VAL_W-1:0] s2_sat;

    logic [5:0] win_rsum, win_csum;
    logic [ROW_W-1:0] win_rlo, win_rhi;
    logic [COL_W-1:0] win_clo, win_chi;
    logic [67:0] prod_full;
    logic [32:0] rate_prod;

    assign h = (cfg.height == 5'd0) ? 5'd1 :
               (cfg.height > 5'(ROWS)) ? 5'(ROWS) : cfg.height;
    assign w = (cfg.width == 5'd0) ? 5'd1 :
               (cfg.width > 5'(COLS)) ? 5'(COLS) : cfg.width;
    assign d = (cfg.dims == 4'd0) ? 4'd1 :
               (cfg.dims > 4'(DIMS)) ? 4'(DIMS) : cfg.dims;
    assign h_last = ROW_W'(h - 5'd1);
    assign w_last = COL_W'(w - 5'd1);
    assign d_last = DIM_W'(d - 4'd1);

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign pipe_empty = !r_s1_v && !r_s2_v;
    assign out_free   = !r_out_valid || o_out.ready;
    assign last_k     = (r_op == OP_COPY) ? (r_k == DIM_W'(DIMS - 1)) : (r_k == d_last);

    // Memory ports
    assign mem_we    = (accept && (i_in.cmd == CMD_WRITE)) ||
                       (r_s2_v && (r_s2_op == OP_UPD));
    assign mem_waddr = (r_state == S_IDLE) ?
                       {i_in.unit_row, i_in.unit_col, i_in.feature_index} :
                       {r_s2_unit, r_s2_k};
    assign mem_wdata = (r_state == S_IDLE) ? i_in.value : s2_sat;
    assign mem_raddr = (r_state == S_IDLE) ?
                       {i_in.unit_row, i_in.unit_col, i_in.feature_index} :
                       {r_row, r_col, r_k};

    som_bmu_wmem u_wmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // First stage: difference and square or product.
    assign s1_ref   = (r_s1_op == OP_SEARCH) ? r_sample[r_s1_k] : r_bvec[r_s1_k];
    assign s1_diff  = 25'(s1_ref) - 25'(mem_rdata);
    assign s1_sq    = s1_diff * s1_diff;
    assign s1_udiff = 25'(r_sample[r_s1_k]) - 25'(mem_rdata);
    assign s1_prod  = s1_udiff * $signed({1'b0, r_m});

    // Second stage: saturating accumulation or rounded weight step.
    assign s2_raw = (r_s2_first ? {(DIST_W+1){1'b0}} : {1'b0, r_acc}) +
                    {3'd0, r_s2_sq};
    assign s2_sum = (s2_raw > {1'b0, DIST_MAX}) ? DIST_MAX : s2_raw[DIST_W-1:0];
    assign s2_mag = r_s2_prod[42] ? 43'(-r_s2_prod) : 43'(r_s2_prod);
    assign s2_rnd = s2_mag + 43'd16384;
    assign s2_step = r_s2_prod[42] ? -$signed({1'b0, s2_rnd[42:15]}) :
                                     $signed({1'b0, s2_rnd[42:15]});
    assign s2_new = 30'(r_s2_w) + 30'(s2_step);
    assign s2_sat = (s2_new > 30'sd8388607)  ? 24'sh7FFFFF :
                    (s2_new < -30'sd8388608) ? 24'sh800000 : s2_new[VAL_W-1:0];

    // Training window around the best unit.
    assign win_rsum = {2'd0, r_best_unit[7:4]} + {1'b0, cfg.radius};
    assign win_csum = {2'd0, r_best_unit[3:0]} + {1'b0, cfg.radius};
    assign win_rlo  = ({1'b0, r_best_unit[7:4]} > cfg.radius) ?
                      ROW_W'({1'b0, r_best_unit[7:4]} - cfg.radius) : '0;
    assign win_clo  = ({1'b0, r_best_unit[3:0]} > cfg.radius) ?
                      COL_W'({1'b0, r_best_unit[3:0]} - cfg.radius) : '0;
    assign win_rhi  = (win_rsum < {2'd0, h_last}) ? win_rsum[ROW_W-1:0] : h_last;
    assign win_chi  = (win_csum < {2'd0, w_last}) ? win_csum[COL_W-1:0] : w_last;

    assign prod_full = {r_ph, 26'd0} + {26'd0, r_pl};
    assign rate_prod = 33'(32'(cfg.rate) * 32'(r_e)) + 33'd16384;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_SEARCH;
            r_train     <= 1'b0;
            r_is_read   <= 1'b0;
            r_best_unit <= '0;
            r_best_sum  <= DIST_MAX;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_v <= (r_state == S_ISSUE);
            if (o_out.valid && o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in.cmd)
                            CMD_READ: begin
                                r_is_read <= 1'b1;
                                r_state   <= S_RDW;
                            end
                            CMD_QUERY, CMD_TRAIN: begin
                                r_sample[i_in.feature_index] <= i_in.value;
                                r_train   <= (i_in.cmd == CMD_TRAIN);
                                r_is_read <= 1'b0;
                                if (i_in.feature_index == d_last) begin
                                    r_best_sum  <= DIST_MAX;
                                    r_best_unit <= '0;
                                    r_row       <= '0;
                                    r_col       <= '0;
                                    r_k         <= '0;
                                    r_op        <= OP_SEARCH;
                                    r_state     <= S_ISSUE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RDW: begin
                    r_rd_val <= mem_rdata;
                    r_state  <= S_EMIT;
                end
                S_ISSUE: begin
                    r_s1_op    <= r_op;
                    r_s1_k     <= r_k;
                    r_s1_first <= (r_k == '0);
                    r_s1_last  <= last_k;
                    r_s1_unit  <= {r_row, r_col};
                    if (last_k) begin
                        r_k <= '0;
                        if (r_op == OP_SEARCH) begin
                            if (r_col == w_last) begin
                                r_col <= '0;
                                if (r_row == h_last) begin
                                    r_state <= S_DRAIN;
                                end else begin
                                    r_row <= r_row + 1'b1;
                                end
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end else begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (pipe_empty) begin
                        r_k <= '0;
                        case (r_op)
                            OP_SEARCH: begin
                                r_op    <= OP_COPY;
                                r_row   <= r_best_unit[7:4];
                                r_col   <= r_best_unit[3:0];
                                r_state <= S_ISSUE;
                            end
                            OP_COPY: r_state <= S_EMIT;
                            OP_TDIST: r_state <= S_MUL_HI;
                            OP_UPD: begin
                                r_op <= OP_TDIST;
                                if (r_col == r_chi) begin
                                    r_col <= r_clo;
                                    if (r_row == r_rhi) begin
                                        r_state <= S_IDLE;
                                    end else begin
                                        r_row   <= r_row + 1'b1;
                                        r_state <= S_ISSUE;
                                    end
                                end else begin
                                    r_col   <= r_col + 1'b1;
                                    r_state <= S_ISSUE;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_is_read ? KIND_READ :
                                       (r_train ? KIND_TRAIN : KIND_QUERY);
                        r_out_row   <= r_is_read ? '0 : r_best_unit[7:4];
                        r_out_col   <= r_is_read ? '0 : r_best_unit[3:0];
                        r_out_dist  <= r_is_read ? '0 : r_best_sum;
                        r_out_rd    <= r_is_read ? r_rd_val : '0;
                        if (!r_is_read && r_train) begin
                            r_rhi   <= win_rhi;
                            r_clo   <= win_clo;
                            r_chi   <= win_chi;
                            r_row   <= win_rlo;
                            r_col   <= win_clo;
                            r_k     <= '0;
                            r_op    <= OP_TDIST;
                            r_state <= S_ISSUE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MUL_HI: begin
                    r_ph    <= 42'(r_dist[51:26] * cfg.scale);
                    r_state <= S_MUL_LO;
                end
                S_MUL_LO: begin
                    r_pl    <= 42'(r_dist[25:0] * cfg.scale);
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    r_e     <= (prod_full[67:48] != '0) ? 16'd0 :
                               EXP_ROM[prod_full[47:40]];
                    r_state <= S_RATE;
                end
                S_RATE: begin
                    r_m     <= rate_prod[31:15];
                    r_op    <= OP_UPD;
                    r_k     <= '0;
                    r_state <= S_ISSUE;
                end
                default: r_state <= S_IDLE;
            endcase

            // Pipeline advance
            r_s2_v     <= r_s1_v;
            r_s2_op    <= r_s1_op;
            r_s2_k     <= r_s1_k;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_unit  <= r_s1_unit;
            r_s2_sq    <= 50'(s1_sq);
            r_s2_prod  <= s1_prod;
            r_s2_w     <= mem_rdata;
            if (r_s1_v && (r_s1_op == OP_COPY)) begin
                r_bvec[r_s1_k] <= mem_rdata;
            end

            if (r_s2_v) begin
                case (r_s2_op)
                    OP_SEARCH: begin
                        r_acc <= s2_sum;
                        if (r_s2_last && ((r_s2_unit == '0) || (s2_sum < r_best_sum))) begin
                            r_best_sum  <= s2_sum;
                            r_best_unit <= r_s2_unit;
                        end
                    end
                    OP_TDIST: begin
                        r_acc <= s2_sum;
                        if (r_s2_last) begin
                            r_dist <= s2_sum;
                        end
                    end
                    OP_UPD: begin
                        if (r_s2_unit == r_best_unit) begin
                            r_bvec[r_s2_k] <= s2_sat;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.result_kind   = r_out_kind;
    assign o_out.best_row      = r_out_row;
    assign o_out.best_col      = r_out_col;
    assign o_out.best_distance = r_out_dist;
    assign o_out.read_value    = r_out_rd;

endmodule
`default_nettype wire

[src/som_bmu_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SOM configuration registers
// APB register file holding map size, feature count and training settings.
// ----------------------------------------------------------------------------
module som_bmu_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [som_bmu_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output som_bmu_pkg::t_cfg                 o_cfg
);
    import som_bmu_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height <= 5'd16;
            r_cfg.width  <= 5'd16;
            r_cfg.dims   <= 4'd8;
            r_cfg.rate   <= 16'd16384;
            r_cfg.scale  <= 16'd256;
            r_cfg.radius <= 5'd1;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_HEIGHT: r_cfg.height <= pwdata[4:0];
                REG_WIDTH:  r_cfg.width  <= pwdata[4:0];
                REG_DIMS:   r_cfg.dims   <= pwdata[3:0];
                REG_RATE:   r_cfg.rate   <= pwdata[15:0];
                REG_SCALE:  r_cfg.scale  <= pwdata[15:0];
                REG_RADIUS: r_cfg.radius <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_HEIGHT: prdata = {27'd0, r_cfg.height};
            REG_WIDTH:  prdata = {27'd0, r_cfg.width};
            REG_DIMS:   prdata = {28'd0, r_cfg.dims};
            REG_RATE:   prdata = {16'd0, r_cfg.rate};
            REG_SCALE:  prdata = {16'd0, r_cfg.scale};
            REG_RADIUS: prdata = {27'd0, r_cfg.radius};
            default:    prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule
`default_nettype wire

[src/som_bmu_wmem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// SOM weight memory
// Simple dual-port weight store with one write and one registered read port.
// ----------------------------------------------------------------------------
module som_bmu_wmem (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [som_bmu_pkg::ADDR_W-1:0]      i_waddr,
    input  wire logic signed [som_bmu_pkg::VAL_W-1:0] i_wdata,
    input  wire logic [som_bmu_pkg::ADDR_W-1:0]      i_raddr,
    output logic signed [som_bmu_pkg::VAL_W-1:0]     o_rdata
);
    import som_bmu_pkg::*;

    logic signed [VAL_W-1:0] r_mem [2**ADDR_W];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
